FILE: rtl/tbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map box collision: shared types and constants
// Holds the request codes, register indexes, reset values, the empty tile
// code and the request type of the iterative divider.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Width of one stored tile number.
  localparam int TILE_W = 12;
  typedef logic [TILE_W-1:0] tile_t;

  // Code of an empty tile (-1 in twelve bits).
  localparam tile_t EMPTY_TILE = '1;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_TILE_W   = 2'd0;
  localparam logic [1:0] REG_TILE_H   = 2'd1;
  localparam logic [1:0] REG_MAP_COLS = 2'd2;
  localparam logic [1:0] REG_MAP_ROWS = 2'd3;

  // Register widths and reset values.
  localparam int TSIZE_W = 8;
  localparam int MSIZE_W = 7;
  localparam logic [TSIZE_W-1:0] TILE_W_RESET   = 8'd32;
  localparam logic [TSIZE_W-1:0] TILE_H_RESET   = 8'd32;
  localparam logic [MSIZE_W-1:0] MAP_COLS_RESET = 7'd64;
  localparam logic [MSIZE_W-1:0] MAP_ROWS_RESET = 7'd64;

  // Divider: sixteen-bit magnitude over an eight-bit tile size.
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = TSIZE_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  // Pixel offset of a tile edge inside the used map.
  localparam int PIX_W = 15;

endpackage

FILE: rtl/tbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map box collision: iterative divider
// Restoring unsigned divider, one quotient bit per cycle. The quotient holds
// after the done pulse until the next start.
// ----------------------------------------------------------------------------
module tbc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbc_pkg::div_req_t             req_i,
  output logic [tbc_pkg::DIV_NUM_W-1:0] quot_o,
  output logic                          done_o
);

  logic [tbc_pkg::DIV_NUM_W-1:0] quot_q;
  logic [tbc_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [tbc_pkg::DIV_DEN_W-1:0] den_q;
  logic [tbc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          done_q;
  logic [tbc_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quot_q[tbc_pkg::DIV_NUM_W-1]};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? tbc_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                 : trial[tbc_pkg::DIV_DEN_W-1:0];
  end

  // Step counter, remainder and the shared dividend/quotient shift register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      quot_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
      cnt_q  <= tbc_pkg::DIV_CNT_W'(tbc_pkg::DIV_NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[tbc_pkg::DIV_NUM_W-2:0], fits};
      rem_q  <= rem_d;
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == tbc_pkg::DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

FILE: rtl/tbc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map box collision: tile store
// Synchronous memory of tile numbers, one write port and one read port with
// the read data registered.
// ----------------------------------------------------------------------------
module tbc_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  tbc_pkg::tile_t     wr_data_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output tbc_pkg::tile_t     rd_data_o
);

  tbc_pkg::tile_t mem [DEPTH];
  tbc_pkg::tile_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/tilemap_box_collision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map box collision
// Keeps a map of tile numbers and tests boxes against the tiles that match a
// target number.
// ----------------------------------------------------------------------------
// After reset the block clears its tile store to empty, one entry per cycle,
// through all MAX_COLS*MAX_ROWS entries (4096 with the default sizes); busy
// stays high until that is done, while register writes are taken at once.
// A write item goes to ST_WRITE, which stores the tile and sets the acknowledge.
// A query runs four dividers in parallel to find the tile span, then reads
// the store one tile per cycle, testing each tile read against the target
// until a hit or the end of the span.
// Each result is shown on done_o for a single cycle and is not held, so the
// receiver must take it when it appears.
// ----------------------------------------------------------------------------
module tilemap_box_collision #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type_i,
  input  logic signed [15:0]             pos_x_i,
  input  logic signed [15:0]             pos_y_i,
  input  logic [9:0]                     box_width_i,
  input  logic [9:0]                     box_height_i,
  input  logic signed [11:0]             tile_value_i,
  // Result channel
  output logic                           done_o,
  output logic                           collided_o,
  output logic                           was_query_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tbc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tbc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW     = tbc_pkg::MSIZE_W;
  localparam int TW     = tbc_pkg::TSIZE_W;
  localparam int PW     = tbc_pkg::PIX_W;
  localparam int NW     = tbc_pkg::DIV_NUM_W;

  // Divider slots.
  localparam int DV_LEFT   = 0;
  localparam int DV_RIGHT  = 1;
  localparam int DV_TOP    = 2;
  localparam int DV_BOTTOM = 3;
  localparam int DV_NUM    = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_SPAN,
    ST_SETUP,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic          empty;
    logic [MW-1:0] lo;
    logic [MW-1:0] hi;
  } span_t;

  // Clamp one axis of the divided span to the used part of the map.
  function automatic span_t calc_span(input logic [NW-1:0] q_lo, input logic lo_neg,
                                      input logic [NW-1:0] q_hi, input logic hi_neg,
                                      input logic [MW-1:0] used);
    logic [NW-1:0] lo;
    logic [NW-1:0] hi;
    logic [NW-1:0] lim;
    span_t         s;
    lo  = lo_neg ? '0 : q_lo;
    hi  = hi_neg ? '0 : q_hi;
    lim = {{(NW-MW){1'b0}}, MW'(used - 1'b1)};
    if (hi > lim) begin
      hi = lim;
    end
    s.empty = (used == '0) || (hi_neg && (q_hi != '0)) || (lo > hi);
    s.lo    = lo[MW-1:0];
    s.hi    = hi[MW-1:0];
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TW-1:0] tile_w_q, tile_h_q;
  logic [MW-1:0] map_cols_q, map_rows_q;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q   <= tbc_pkg::TILE_W_RESET;
      tile_h_q   <= tbc_pkg::TILE_H_RESET;
      map_cols_q <= tbc_pkg::MAP_COLS_RESET;
      map_rows_q <= tbc_pkg::MAP_ROWS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tbc_pkg::REG_TILE_W:   tile_w_q   <= pwdata[TW-1:0];
        tbc_pkg::REG_TILE_H:   tile_h_q   <= pwdata[TW-1:0];
        tbc_pkg::REG_MAP_COLS: map_cols_q <= pwdata[MW-1:0];
        tbc_pkg::REG_MAP_ROWS: map_rows_q <= pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      tbc_pkg::REG_TILE_W:   prdata = tbc_pkg::APB_DATA_W'(tile_w_q);
      tbc_pkg::REG_TILE_H:   prdata = tbc_pkg::APB_DATA_W'(tile_h_q);
      tbc_pkg::REG_MAP_COLS: prdata = tbc_pkg::APB_DATA_W'(map_cols_q);
      tbc_pkg::REG_MAP_ROWS: prdata = tbc_pkg::APB_DATA_W'(map_rows_q);
      default:               prdata = '0;
    endcase
  end

  // Map size in use, limited to the store dimensions.
  logic [MW-1:0] used_cols, used_rows;

  assign used_cols = (32'(map_cols_q) > MAX_COLS) ? MW'(MAX_COLS) : map_cols_q;
  assign used_rows = (32'(map_rows_q) > MAX_ROWS) ? MW'(MAX_ROWS) : map_rows_q;

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_e          state_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic            done_q, collided_q, was_query_q;
  logic            accept, acc_query;

  // Write item
  logic            wr_ok_q;
  logic [ADDR_W-1:0] wr_addr_q;
  tbc_pkg::tile_t  wr_data_q;
  logic            wr_in_range;

  // Query item
  logic [15:0]     left_q, top_q;
  logic [16:0]     right_q, bottom_q;
  tbc_pkg::tile_t  target_q;
  logic            xr_neg_q, yr_neg_q;
  logic [MW-1:0]   x0_q, x1_q, y0_q, y1_q;
  logic            span_ok_q;

  // Walker
  logic [MW-1:0]   x_q, y_q;
  logic [ADDR_W-1:0] addr_q, rowaddr_q;
  logic [PW-1:0]   tl0_q, tl_q, tt_q;
  logic            issue_q, pend_q;
  logic [PW-1:0]   pend_tl_q, pend_tt_q;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign acc_query = accept && (req_type_i == tbc_pkg::REQ_QUERY);

  assign wr_in_range = !pos_x_i[15] && ($unsigned(pos_x_i) < {9'd0, used_cols}) &&
                       !pos_y_i[15] && ($unsigned(pos_y_i) < {9'd0, used_rows});

  // --------------------------------------------------------------------------
  // Divider operands: magnitudes of left, right-1, top and bottom-1
  // --------------------------------------------------------------------------
  logic [16:0] lx_neg, ly_neg;
  logic [17:0] rx, ry, rx_neg, ry_neg;
  logic [16:0] right_in, bottom_in;
  tbc_pkg::div_req_t div_req [DV_NUM];
  logic [NW-1:0]     div_quot [DV_NUM];
  logic [DV_NUM-1:0] div_done;

  always_comb begin
    lx_neg    = 17'd0 - {pos_x_i[15], pos_x_i};
    ly_neg    = 17'd0 - {pos_y_i[15], pos_y_i};
    right_in  = {pos_x_i[15], pos_x_i} + {7'd0, box_width_i};
    bottom_in = {pos_y_i[15], pos_y_i} + {7'd0, box_height_i};
    rx        = {right_in[16], right_in} - 18'd1;
    ry        = {bottom_in[16], bottom_in} - 18'd1;
    rx_neg    = 18'd0 - rx;
    ry_neg    = 18'd0 - ry;

    div_req[DV_LEFT].start   = acc_query;
    div_req[DV_LEFT].num     = pos_x_i[15] ? lx_neg[NW-1:0] : $unsigned(pos_x_i);
    div_req[DV_LEFT].den     = tile_w_q;
    div_req[DV_RIGHT].start  = acc_query;
    div_req[DV_RIGHT].num    = rx[17] ? rx_neg[NW-1:0] : rx[NW-1:0];
    div_req[DV_RIGHT].den    = tile_w_q;
    div_req[DV_TOP].start    = acc_query;
    div_req[DV_TOP].num      = pos_y_i[15] ? ly_neg[NW-1:0] : $unsigned(pos_y_i);
    div_req[DV_TOP].den      = tile_h_q;
    div_req[DV_BOTTOM].start = acc_query;
    div_req[DV_BOTTOM].num   = ry[17] ? ry_neg[NW-1:0] : ry[NW-1:0];
    div_req[DV_BOTTOM].den   = tile_h_q;
  end

  for (genvar i = 0; i < DV_NUM; i++) begin : g_div
    tbc_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (div_req[i]),
      .quot_o (div_quot[i]),
      .done_o (div_done[i])
    );
  end

  // Span of covered tiles on each axis.
  span_t span_x, span_y;

  assign span_x = calc_span(div_quot[DV_LEFT], left_q[15], div_quot[DV_RIGHT], xr_neg_q,
                            used_cols);
  assign span_y = calc_span(div_quot[DV_TOP], top_q[15], div_quot[DV_BOTTOM], yr_neg_q,
                            used_rows);

  // --------------------------------------------------------------------------
  // Tile store
  // --------------------------------------------------------------------------
  logic              st_wr_en;
  logic [ADDR_W-1:0] st_wr_addr;
  tbc_pkg::tile_t    st_wr_data;
  logic              st_rd_en;
  tbc_pkg::tile_t    st_rd_data;

  // The clearing pass and write items share the write port.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      st_wr_en   = 1'b1;
      st_wr_addr = clr_addr_q;
      st_wr_data = tbc_pkg::EMPTY_TILE;
    end else begin
      st_wr_en   = (state_q == ST_WRITE) && wr_ok_q;
      st_wr_addr = wr_addr_q;
      st_wr_data = wr_data_q;
    end
  end

  assign st_rd_en = (state_q == ST_WALK) && issue_q;

  tbc_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (st_wr_data),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (st_rd_data)
  );

  // --------------------------------------------------------------------------
  // Match and overlap test on the tile read in the previous cycle
  // --------------------------------------------------------------------------
  logic [PW:0]        tl_end, tt_end;
  logic signed [17:0] l18, r18, t18, b18;
  logic               overlap, hit;

  always_comb begin
    tl_end  = {1'b0, pend_tl_q} + {{(PW+1-TW){1'b0}}, tile_w_q};
    tt_end  = {1'b0, pend_tt_q} + {{(PW+1-TW){1'b0}}, tile_h_q};
    l18     = $signed({{2{left_q[15]}}, left_q});
    t18     = $signed({{2{top_q[15]}}, top_q});
    r18     = $signed({right_q[16], right_q});
    b18     = $signed({bottom_q[16], bottom_q});
    overlap = (l18 < $signed({2'b00, tl_end})) &&
              (r18 > $signed({3'b000, pend_tl_q})) &&
              (t18 < $signed({2'b00, tt_end})) &&
              (b18 > $signed({3'b000, pend_tt_q}));
    hit     = pend_q && (st_rd_data == target_q) && overlap;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      done_q      <= 1'b0;
      collided_q  <= 1'b0;
      was_query_q <= 1'b0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      wr_ok_q     <= 1'b0;
      span_ok_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pend_q <= 1'b0;
      case (state_q)
        // Sweep the store to empty after reset.
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        // Take an item.
        ST_IDLE: begin
          if (start) begin
            left_q    <= $unsigned(pos_x_i);
            top_q     <= $unsigned(pos_y_i);
            right_q   <= right_in;
            bottom_q  <= bottom_in;
            target_q  <= $unsigned(tile_value_i);
            xr_neg_q  <= rx[17];
            yr_neg_q  <= ry[17];
            wr_ok_q   <= wr_in_range;
            wr_addr_q <= ADDR_W'(32'(pos_y_i[MW-1:0]) * MAX_COLS + 32'(pos_x_i[MW-1:0]));
            wr_data_q <= $unsigned(tile_value_i);
            if (req_type_i == tbc_pkg::REQ_QUERY) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end

        // Store the tile if it lies in the map, and acknowledge.
        ST_WRITE: begin
          done_q      <= 1'b1;
          collided_q  <= 1'b0;
          was_query_q <= 1'b0;
          state_q     <= ST_IDLE;
        end

        // Wait for the span divisions.
        ST_DIV: begin
          if (&div_done) begin
            state_q <= ST_SPAN;
          end
        end

        // Clamp the span to the map.
        ST_SPAN: begin
          x0_q      <= span_x.lo;
          x1_q      <= span_x.hi;
          y0_q      <= span_y.lo;
          y1_q      <= span_y.hi;
          span_ok_q <= !span_x.empty && !span_y.empty &&
                       (tile_w_q != '0) && (tile_h_q != '0);
          state_q   <= ST_SETUP;
        end

        // Load the walker at the first tile of the span, or report no hit if it is empty.
        ST_SETUP: begin
          if (!span_ok_q) begin
            done_q      <= 1'b1;
            collided_q  <= 1'b0;
            was_query_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            x_q       <= x0_q;
            y_q       <= y0_q;
            rowaddr_q <= ADDR_W'(32'(y0_q) * MAX_COLS + 32'(x0_q));
            addr_q    <= ADDR_W'(32'(y0_q) * MAX_COLS + 32'(x0_q));
            tl0_q     <= PW'(x0_q) * PW'(tile_w_q);
            tl_q      <= PW'(x0_q) * PW'(tile_w_q);
            tt_q      <= PW'(y0_q) * PW'(tile_h_q);
            issue_q   <= 1'b1;
            state_q   <= ST_WALK;
          end
        end

        // Read one tile per cycle, test the one read in the cycle before.
        ST_WALK: begin
          pend_q    <= issue_q;
          pend_tl_q <= tl_q;
          pend_tt_q <= tt_q;
          if (issue_q) begin
            if (x_q == x1_q) begin
              if (y_q == y1_q) begin
                issue_q <= 1'b0;
              end else begin
                y_q       <= y_q + 1'b1;
                x_q       <= x0_q;
                rowaddr_q <= rowaddr_q + ADDR_W'(MAX_COLS);
                addr_q    <= rowaddr_q + ADDR_W'(MAX_COLS);
                tl_q      <= tl0_q;
                tt_q      <= tt_q + PW'(tile_h_q);
              end
            end else begin
              x_q    <= x_q + 1'b1;
              addr_q <= addr_q + 1'b1;
              tl_q   <= tl_q + PW'(tile_w_q);
            end
          end
          if (hit) begin
            issue_q     <= 1'b0;
            pend_q      <= 1'b0;
            done_q      <= 1'b1;
            collided_q  <= 1'b1;
            was_query_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (!issue_q && !pend_q) begin
            done_q      <= 1'b1;
            collided_q  <= 1'b0;
            was_query_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o      = done_q;
  assign collided_o  = collided_q;
  assign was_query_o = was_query_q;

endmodule

FILE: rtl/tbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map box collision: port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
module tbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic collided_o,
  input logic was_query_o
);

  // A taken item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy afterwards");

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // One result per item: never two result cycles in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // No result appears without an item at work.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o)
    else $error("result with no item in progress");

  // A write acknowledge never reports a hit.
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !was_query_o) |-> !collided_o)
    else $error("write acknowledge reports a collision");

endmodule

bind tilemap_box_collision tbc_checker u_tbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .collided_o  (collided_o),
  .was_query_o (was_query_o)
);
